>>> rtl/trsc_pkg.sv
// Shared types and word-class codes for the readout stream checker.
package trsc_pkg;

    // Word classes, decided by the front stage
    typedef enum logic [3:0] {
        K_GEO,
        K_GEO_BAD,
        K_HEADER,
        K_SEPARATOR,
        K_TRIGGER,
        K_TAG,
        K_DATA,
        K_TDC_ERR,
        K_UNEXPECTED
    } t_kind;

    // Top nibble codes
    localparam logic [3:0]  TOP_GEO       = 4'hC;
    localparam logic [3:0]  TOP_HEADER    = 4'h2;
    localparam logic [3:0]  TOP_SEPARATOR = 4'hE;
    localparam logic [3:0]  TOP_TRIGGER   = 4'hA;
    localparam logic [3:0]  TOP_DATA_LO   = 4'h4;
    localparam logic [3:0]  TOP_DATA_HI   = 4'h5;
    localparam logic [3:0]  TOP_TDC_ERR   = 4'h6;
    localparam logic [7:0]  HEADER_BYTE   = 8'h20;
    localparam logic [31:0] TAG_WORD      = 32'hDEADFACE;

    // Separator count special case: a full buffer reports 1022 after 1020 words
    localparam logic [9:0]  REP_OVERFLOW  = 10'd1022;
    localparam int unsigned CNT_OVERFLOW  = 1020;

    // Error flag bit positions
    localparam int unsigned F_REPEAT   = 0;
    localparam int unsigned F_GEOBIT   = 1;
    localparam int unsigned F_HALFORD  = 2;
    localparam int unsigned F_SEPMISS  = 3;
    localparam int unsigned F_PHASE    = 4;
    localparam int unsigned F_GEOMISS  = 5;
    localparam int unsigned F_HDRMISS  = 6;
    localparam int unsigned F_OVERFLOW = 7;
    localparam int unsigned F_COUNT    = 8;
    localparam int unsigned F_TRGHALF  = 9;
    localparam int unsigned F_TDC      = 10;
    localparam int unsigned F_UNEXP    = 11;

    localparam int unsigned FLAG_W = 12;

    // Depth of the queue between front and back
    localparam int unsigned Q_DEPTH = 2;

    // One classified request
    typedef struct packed {
        logic [31:0] word;
        logic        record_start;
        logic        event_start;
        t_kind       kind;
        logic        header_exact;
    } t_item;

endpackage

>>> rtl/trsc_front.sv
// Front stage: accepts readout words and classifies them by top nibble.
module trsc_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  logic [31:0]     i_word,
    input  logic            i_record_start,
    input  logic            i_event_start,
    output logic            o_item_valid,
    input  logic            i_item_stall,
    output trsc_pkg::t_item o_item
);
    import trsc_pkg::*;

    logic  r_valid;
    t_item r_item;
    t_item n_item;
    logic  w_take;

    // Classify the incoming word
    always_comb begin
        n_item              = '0;
        n_item.word         = i_word;
        n_item.record_start = i_record_start;
        n_item.event_start  = i_event_start;
        n_item.header_exact = (i_word[31:24] == HEADER_BYTE);
        if (i_word[31:28] == TOP_GEO) begin
            n_item.kind = (i_word[27:8] == '0) ? K_GEO : K_GEO_BAD;
        end else if (i_word[31:28] == TOP_HEADER) begin
            n_item.kind = K_HEADER;
        end else if (i_word[31:28] == TOP_SEPARATOR) begin
            n_item.kind = K_SEPARATOR;
        end else if (i_word[31:28] == TOP_TRIGGER) begin
            n_item.kind = K_TRIGGER;
        end else if (i_word == TAG_WORD) begin
            n_item.kind = K_TAG;
        end else if (i_word[31:28] == TOP_DATA_LO || i_word[31:28] == TOP_DATA_HI) begin
            n_item.kind = K_DATA;
        end else if (i_word[31:28] == TOP_TDC_ERR) begin
            n_item.kind = K_TDC_ERR;
        end else begin
            n_item.kind = K_UNEXPECTED;
        end
    end

    // Hold the stage while the queue is full
    assign o_stall = r_valid && i_item_stall;
    assign w_take  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item <= n_item;
        end
    end

    assign o_item_valid = r_valid;
    assign o_item       = r_item;

endmodule

>>> rtl/trsc_queue.sv
// Short request queue between the front and back stages.
module trsc_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  trsc_pkg::t_item i_item,
    output logic            o_valid,
    input  logic            i_stall,
    output trsc_pkg::t_item o_item
);
    import trsc_pkg::*;

    localparam int unsigned AW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int unsigned CW = $clog2(Q_DEPTH + 1);

    t_item           r_mem [Q_DEPTH];
    logic [AW-1:0]   r_wr_ptr;
    logic [AW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            w_push;
    logic            w_pop;

    assign o_stall = (r_count == CW'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign w_push  = i_valid && !o_stall;
    assign w_pop   = o_valid && !i_stall;

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Store the incoming request
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

>>> rtl/trsc_back.sv
// Back stage: framing state, error flag evaluation and output register.
module trsc_back #(
    parameter int unsigned COUNT_WIDTH = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_item_valid,
    output logic            o_item_stall,
    input  trsc_pkg::t_item i_item,
    output logic            o_valid,
    input  logic            i_stall,
    output logic [11:0]     o_error_flags,
    output logic [6:0]      o_tray_number,
    output logic            o_tray_half,
    output logic            o_tray_known,
    output logic [9:0]      o_sep_count,
    output logic [15:0]     o_actual_count,
    output logic [11:0]     o_expected_phase,
    output logic            o_first_in_record
);
    import trsc_pkg::*;

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    // Framing state
    logic                   r_half_parity;
    logic [31:0]            r_prev_word;
    logic                   r_hdr_pending;
    logic                   r_sep_pending;
    logic                   r_await_hdr;
    logic [11:0]            r_phase;
    logic [COUNT_WIDTH-1:0] r_count;
    logic [6:0]             r_tray;
    logic                   r_half;
    logic                   r_tray_seen;
    logic                   r_reported;

    logic                   n_half_parity;
    logic [31:0]            n_prev_word;
    logic                   n_hdr_pending;
    logic                   n_sep_pending;
    logic                   n_await_hdr;
    logic [11:0]            n_phase;
    logic [COUNT_WIDTH-1:0] n_count;
    logic [6:0]             n_tray;
    logic                   n_half;
    logic                   n_tray_seen;
    logic                   n_reported;
    logic [FLAG_W-1:0]      n_flags;
    logic [9:0]             n_rep;
    logic                   n_first;
    logic [COUNT_WIDTH-1:0] w_prior;
    logic [15:0]            w_actual;

    // Output register
    logic                   r_valid;
    logic [FLAG_W-1:0]      r_flags;
    logic [6:0]             r_out_tray;
    logic                   r_out_half;
    logic                   r_out_seen;
    logic [9:0]             r_rep;
    logic [15:0]            r_actual;
    logic [11:0]            r_out_phase;
    logic                   r_first;

    logic                   w_take;

    assign o_item_stall = r_valid && i_stall;
    assign w_take       = i_item_valid && !o_item_stall;

    // Evaluate one request against the framing state
    always_comb begin
        n_half_parity = r_half_parity;
        n_prev_word   = r_prev_word;
        n_hdr_pending = r_hdr_pending;
        n_sep_pending = r_sep_pending;
        n_await_hdr   = r_await_hdr;
        n_phase       = r_phase;
        n_count       = r_count;
        n_tray        = r_tray;
        n_half        = r_half;
        n_tray_seen   = r_tray_seen;
        n_reported    = r_reported;
        n_flags       = '0;
        n_rep         = '0;

        // drop record state at a record or event boundary
        if (i_item.event_start) begin
            n_half_parity = 1'b0;
        end
        if (i_item.record_start || i_item.event_start) begin
            n_prev_word   = '1;
            n_hdr_pending = 1'b0;
            n_sep_pending = 1'b0;
            n_await_hdr   = 1'b1;
            n_phase       = '0;
            n_count       = '0;
            n_tray        = '0;
            n_half        = 1'b0;
            n_tray_seen   = 1'b0;
            n_reported    = 1'b0;
        end

        w_prior = n_count;
        if (n_count != CNT_MAX) begin
            n_count = n_count + 1'b1;
        end

        n_flags[F_REPEAT] = (i_item.word == n_prev_word);
        n_prev_word       = i_item.word;

        case (i_item.kind)
            K_GEO: begin
                n_count              = '0;
                n_tray               = i_item.word[7:1];
                n_half               = i_item.word[0];
                n_tray_seen          = 1'b1;
                n_flags[F_HALFORD]   = (i_item.word[0] == n_half_parity);
                n_half_parity        = i_item.word[0];
                n_flags[F_SEPMISS]   = n_sep_pending;
                n_hdr_pending        = 1'b1;
                n_sep_pending        = 1'b1;
            end
            K_GEO_BAD: begin
                n_count            = '0;
                n_tray             = i_item.word[7:1];
                n_half             = i_item.word[0];
                n_tray_seen        = 1'b1;
                n_flags[F_GEOBIT]  = 1'b1;
            end
            K_HEADER: begin
                if (n_await_hdr) begin
                    n_phase     = i_item.word[11:0];
                    n_await_hdr = 1'b0;
                end else if (i_item.word[11:0] != n_phase) begin
                    n_flags[F_PHASE] = 1'b1;
                end
                n_flags[F_GEOMISS] = !n_hdr_pending && i_item.header_exact;
                n_hdr_pending      = 1'b0;
            end
            K_SEPARATOR: begin
                n_rep         = i_item.word[17:8];
                n_sep_pending = 1'b0;
                if (n_hdr_pending) begin
                    n_flags[F_HDRMISS] = 1'b1;
                    n_hdr_pending      = 1'b0;
                end else if (n_rep == REP_OVERFLOW
                             && w_prior == COUNT_WIDTH'(CNT_OVERFLOW)) begin
                    n_flags[F_OVERFLOW] = 1'b1;
                end else if (COUNT_WIDTH'(n_rep) != w_prior) begin
                    n_flags[F_COUNT] = 1'b1;
                end
                n_count = '0;
            end
            K_TRIGGER: begin
                n_count            = '0;
                n_flags[F_TRGHALF] = n_half_parity;
                n_half_parity      = 1'b0;
                if (n_sep_pending) begin
                    n_flags[F_SEPMISS] = 1'b1;
                end else if (n_hdr_pending) begin
                    n_flags[F_HDRMISS] = 1'b1;
                end
                n_sep_pending = 1'b0;
                n_hdr_pending = 1'b0;
            end
            K_TAG: begin
                n_count = '0;
            end
            K_DATA: begin
                n_count = n_count;
            end
            K_TDC_ERR: begin
                n_flags[F_TDC] = 1'b1;
            end
            default: begin
                n_flags[F_UNEXP] = 1'b1;
            end
        endcase

        n_first = (n_flags != '0) && !n_reported;
        if (n_flags != '0) begin
            n_reported = 1'b1;
        end
    end

    // Saturate the prior count into the 16-bit field
    generate
        if (COUNT_WIDTH > 16) begin : g_sat
            assign w_actual = (|w_prior[COUNT_WIDTH-1:16]) ? 16'hFFFF : w_prior[15:0];
        end else begin : g_ext
            assign w_actual = 16'(w_prior);
        end
    endgenerate

    // Update state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_parity <= 1'b0;
            r_prev_word   <= '1;
            r_hdr_pending <= 1'b0;
            r_sep_pending <= 1'b0;
            r_await_hdr   <= 1'b1;
            r_phase       <= '0;
            r_count       <= '0;
            r_tray        <= '0;
            r_half        <= 1'b0;
            r_tray_seen   <= 1'b0;
            r_reported    <= 1'b0;
            r_valid       <= 1'b0;
        end else begin
            if (w_take) begin
                r_half_parity <= n_half_parity;
                r_prev_word   <= n_prev_word;
                r_hdr_pending <= n_hdr_pending;
                r_sep_pending <= n_sep_pending;
                r_await_hdr   <= n_await_hdr;
                r_phase       <= n_phase;
                r_count       <= n_count;
                r_tray        <= n_tray;
                r_half        <= n_half;
                r_tray_seen   <= n_tray_seen;
                r_reported    <= n_reported;
            end
            if (!o_item_stall) begin
                r_valid <= i_item_valid;
            end
        end
    end

    // Load the result register
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_flags     <= n_flags;
            r_out_tray  <= n_tray;
            r_out_half  <= n_half;
            r_out_seen  <= n_tray_seen;
            r_rep       <= n_rep;
            r_actual    <= w_actual;
            r_out_phase <= n_phase;
            r_first     <= n_first;
        end
    end

    assign o_valid           = r_valid;
    assign o_error_flags     = r_flags;
    assign o_tray_number     = r_out_tray;
    assign o_tray_half       = r_out_half;
    assign o_tray_known      = r_out_seen;
    assign o_sep_count       = r_rep;
    assign o_actual_count    = r_actual;
    assign o_expected_phase  = r_out_phase;
    assign o_first_in_record = r_first;

endmodule

>>> rtl/tdc_readout_stream_checker.sv
// Top level of the readout stream checker: front, queue and back stages.
//
// Usage: one 32-bit readout word enters per request on the input channel
// (i_valid / o_stall) together with its record and event start marks.
// Each word yields exactly one result on the output channel (o_valid /
// i_stall): twelve error flags, the tray context, the separator count
// field, the word count since the last framing word and the latched phase.
// A request is taken at a rising edge with valid high and stall low.
// The word passes the front register, then a queue entry; the back stage
// registers the result as it pops the queue. Throughput: one word per
// clock, sustained while the receiver does not stall; the framing state in
// the back stage updates once per word.
// When the receiver stalls, the result register holds, the queue fills and
// the front register then raises o_stall; no request is lost or repeated.
// Reset (i_rst_n low, synchronous) empties every stage and returns the
// framing state to its start: no tray known, first header awaited, parity
// and word count cleared.
module tdc_readout_stream_checker #(
    parameter int unsigned COUNT_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_word,
    input  logic        i_record_start,
    input  logic        i_event_start,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [11:0] o_error_flags,
    output logic [6:0]  o_tray_number,
    output logic        o_tray_half,
    output logic        o_tray_known,
    output logic [9:0]  o_sep_count,
    output logic [15:0] o_actual_count,
    output logic [11:0] o_expected_phase,
    output logic        o_first_in_record
);
    import trsc_pkg::*;

    logic  w_f_valid;
    logic  w_f_stall;
    t_item w_f_item;
    logic  w_q_valid;
    logic  w_q_stall;
    t_item w_q_item;

    trsc_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_word         (i_word),
        .i_record_start (i_record_start),
        .i_event_start  (i_event_start),
        .o_item_valid   (w_f_valid),
        .i_item_stall   (w_f_stall),
        .o_item         (w_f_item)
    );

    trsc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_valid),
        .o_stall (w_f_stall),
        .i_item  (w_f_item),
        .o_valid (w_q_valid),
        .i_stall (w_q_stall),
        .o_item  (w_q_item)
    );

    trsc_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_item_valid      (w_q_valid),
        .o_item_stall      (w_q_stall),
        .i_item            (w_q_item),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_error_flags     (o_error_flags),
        .o_tray_number     (o_tray_number),
        .o_tray_half       (o_tray_half),
        .o_tray_known      (o_tray_known),
        .o_sep_count       (o_sep_count),
        .o_actual_count    (o_actual_count),
        .o_expected_phase  (o_expected_phase),
        .o_first_in_record (o_first_in_record)
    );

endmodule

>>> tb/tdc_readout_stream_checker_tb.sv
// Self-checking testbench for the readout stream checker: directed table, bursts, random records.
`timescale 1ns / 1ps

module tdc_readout_stream_checker_tb;
    import trsc_pkg::*;

    localparam int unsigned N_DIRECTED   = 25;
    localparam int unsigned RANDOM_ITEMS = 510;
    localparam int unsigned BURST_DATA   = 30;
    localparam int unsigned HOLD_CYCLES  = 80;
    localparam int unsigned TAIL_CYCLES  = 10;
    localparam int unsigned WD_LIMIT     = 2000;
    localparam int unsigned MAX_REPORTS  = 10;
    localparam int unsigned IDLE_PCT     = 38;

    // Error flag masks
    localparam logic [11:0] M_NONE     = '0;
    localparam logic [11:0] M_REPEAT   = 12'(1) << F_REPEAT;
    localparam logic [11:0] M_GEOBIT   = 12'(1) << F_GEOBIT;
    localparam logic [11:0] M_HALFORD  = 12'(1) << F_HALFORD;
    localparam logic [11:0] M_SEPMISS  = 12'(1) << F_SEPMISS;
    localparam logic [11:0] M_PHASE    = 12'(1) << F_PHASE;
    localparam logic [11:0] M_GEOMISS  = 12'(1) << F_GEOMISS;
    localparam logic [11:0] M_HDRMISS  = 12'(1) << F_HDRMISS;
    localparam logic [11:0] M_OVERFLOW = 12'(1) << F_OVERFLOW;
    localparam logic [11:0] M_COUNT    = 12'(1) << F_COUNT;
    localparam logic [11:0] M_TRGHALF  = 12'(1) << F_TRGHALF;
    localparam logic [11:0] M_TDC      = 12'(1) << F_TDC;
    localparam logic [11:0] M_UNEXP    = 12'(1) << F_UNEXP;

    // One checked word as the block reports it
    typedef struct packed {
        logic [11:0] flags;
        logic [6:0]  tray;
        logic        half;
        logic        known;
        logic [9:0]  rep_count;
        logic [15:0] act_count;
        logic [11:0] phase;
        logic        lead;
    } word_check_t;

    // Framing state tracked alongside the block
    typedef struct packed {
        logic        half_parity;
        logic [31:0] prev_word;
        logic        hdr_pend;
        logic        sep_pend;
        logic        await_hdr;
        logic [11:0] phase;
        logic [15:0] count;
        logic [6:0]  tray;
        logic        tray_half;
        logic        tray_seen;
        logic        reported;
    } frame_state_t;

    // Directed request with optional hand-typed flags
    typedef struct packed {
        logic [31:0] word;
        logic        rec_start;
        logic        evt_start;
        logic        typed;
        logic [11:0] flags;
    } stim_row_t;

    localparam stim_row_t DIRECTED [N_DIRECTED] = '{
        '{32'hFFFFFFFF, 1'b1, 1'b1, 1'b1, M_UNEXP | M_REPEAT},
        '{32'h00000000, 1'b0, 1'b0, 1'b1, M_UNEXP},
        '{32'hC0000005, 1'b0, 1'b0, 1'b0, M_NONE},
        '{32'h20000ABC, 1'b0, 1'b0, 1'b0, M_NONE},
        '{32'h40000001, 1'b0, 1'b0, 1'b0, M_NONE},
        '{32'h5FFFFFFF, 1'b0, 1'b0, 1'b0, M_NONE},
        '{32'h20000123, 1'b0, 1'b0, 1'b1, M_PHASE | M_GEOMISS},
        '{32'hE0000200, 1'b0, 1'b0, 1'b1, M_COUNT},
        '{32'h60000000, 1'b0, 1'b0, 1'b1, M_TDC},
        '{32'hA0000000, 1'b0, 1'b0, 1'b1, M_TRGHALF},
        '{32'hA0000000, 1'b0, 1'b0, 1'b1, M_REPEAT},
        '{32'hDEADFACE, 1'b0, 1'b0, 1'b0, M_NONE},
        '{32'hC1234500, 1'b0, 1'b0, 1'b1, M_GEOBIT},
        '{32'hE0000000, 1'b1, 1'b0, 1'b0, M_NONE},
        '{32'hC0000000, 1'b0, 1'b0, 1'b1, M_HALFORD},
        '{32'hC00000FF, 1'b0, 1'b0, 1'b1, M_SEPMISS},
        '{32'hE003FC00, 1'b0, 1'b0, 1'b1, M_HDRMISS},
        '{32'h21000FFF, 1'b0, 1'b0, 1'b0, M_NONE},
        '{32'h20000FFF, 1'b0, 1'b0, 1'b1, M_GEOMISS},
        '{32'h7FFFFFFF, 1'b0, 1'b1, 1'b1, M_UNEXP},
        '{32'h80000000, 1'b0, 1'b0, 1'b1, M_UNEXP},
        '{32'hDEADFACF, 1'b0, 1'b0, 1'b1, M_UNEXP},
        '{32'h6FFFFFFF, 1'b0, 1'b0, 1'b1, M_TDC},
        '{32'h6FFFFFFF, 1'b0, 1'b0, 1'b1, M_TDC | M_REPEAT},
        '{32'hA0000001, 1'b0, 1'b0, 1'b0, M_NONE}
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [31:0] i_word;
    logic        i_record_start;
    logic        i_event_start;
    logic        o_valid;
    logic        i_stall;
    logic [11:0] o_error_flags;
    logic [6:0]  o_tray_number;
    logic        o_tray_half;
    logic        o_tray_known;
    logic [9:0]  o_sep_count;
    logic [15:0] o_actual_count;
    logic [11:0] o_expected_phase;
    logic        o_first_in_record;

    frame_state_t frame_st;
    word_check_t  pending_checks[$];
    word_check_t  want_res;
    word_check_t  got_res;
    int unsigned  mismatches;
    int unsigned  n_words;
    int unsigned  n_results;
    int unsigned  n_records;
    logic [11:0]  flags_seen;
    logic         src_idle_en;
    logic         sink_idle_en;
    logic         hold_req;
    int unsigned  hold_left;

    tdc_readout_stream_checker i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_word            (i_word),
        .i_record_start    (i_record_start),
        .i_event_start     (i_event_start),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_error_flags     (o_error_flags),
        .o_tray_number     (o_tray_number),
        .o_tray_half       (o_tray_half),
        .o_tray_known      (o_tray_known),
        .o_sep_count       (o_sep_count),
        .o_actual_count    (o_actual_count),
        .o_expected_phase  (o_expected_phase),
        .o_first_in_record (o_first_in_record)
    );

    // Clock generation
    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Return per-record framing state to its start; parity is kept
    function automatic void clear_record();
        frame_st.prev_word = '1;
        frame_st.hdr_pend  = 1'b0;
        frame_st.sep_pend  = 1'b0;
        frame_st.await_hdr = 1'b1;
        frame_st.phase     = '0;
        frame_st.count     = '0;
        frame_st.tray      = '0;
        frame_st.tray_half = 1'b0;
        frame_st.tray_seen = 1'b0;
        frame_st.reported  = 1'b0;
    endfunction

    // Classify one word, advance the framing state and return its check result
    function automatic word_check_t check_word(input logic [31:0] w, input logic rs,
                                               input logic es);
        word_check_t r;
        logic [15:0] prior;
        r = '0;
        if (es) frame_st.half_parity = 1'b0;
        if (rs || es) clear_record();

        prior = frame_st.count;
        if (frame_st.count != '1) frame_st.count = frame_st.count + 16'd1;

        if (w == frame_st.prev_word) r.flags[F_REPEAT] = 1'b1;
        frame_st.prev_word = w;

        case (w[31:28])
            TOP_GEO: begin
                frame_st.count     = '0;
                frame_st.tray      = w[7:1];
                frame_st.tray_half = w[0];
                frame_st.tray_seen = 1'b1;
                if (w[27:8] != '0) begin
                    r.flags[F_GEOBIT] = 1'b1;
                end else begin
                    if (w[0] == frame_st.half_parity) r.flags[F_HALFORD] = 1'b1;
                    frame_st.half_parity = w[0];
                    if (frame_st.sep_pend) r.flags[F_SEPMISS] = 1'b1;
                    frame_st.hdr_pend = 1'b1;
                    frame_st.sep_pend = 1'b1;
                end
            end
            TOP_HEADER: begin
                if (frame_st.await_hdr) begin
                    frame_st.phase     = w[11:0];
                    frame_st.await_hdr = 1'b0;
                end else if (w[11:0] != frame_st.phase) begin
                    r.flags[F_PHASE] = 1'b1;
                end
                if (!frame_st.hdr_pend && w[31:24] == HEADER_BYTE) r.flags[F_GEOMISS] = 1'b1;
                frame_st.hdr_pend = 1'b0;
            end
            TOP_SEPARATOR: begin
                r.rep_count       = w[17:8];
                frame_st.sep_pend = 1'b0;
                if (frame_st.hdr_pend) begin
                    r.flags[F_HDRMISS] = 1'b1;
                    frame_st.hdr_pend  = 1'b0;
                end else if (r.rep_count == REP_OVERFLOW && prior == 16'(CNT_OVERFLOW)) begin
                    r.flags[F_OVERFLOW] = 1'b1;
                end else if (16'(r.rep_count) != prior) begin
                    r.flags[F_COUNT] = 1'b1;
                end
                frame_st.count = '0;
            end
            TOP_TRIGGER: begin
                frame_st.count = '0;
                if (frame_st.half_parity) r.flags[F_TRGHALF] = 1'b1;
                frame_st.half_parity = 1'b0;
                if (frame_st.sep_pend) r.flags[F_SEPMISS] = 1'b1;
                else if (frame_st.hdr_pend) r.flags[F_HDRMISS] = 1'b1;
                frame_st.sep_pend = 1'b0;
                frame_st.hdr_pend = 1'b0;
            end
            TOP_DATA_LO, TOP_DATA_HI: begin
            end
            TOP_TDC_ERR: begin
                r.flags[F_TDC] = 1'b1;
            end
            default: begin
                // the tag word is the only legal word outside the known nibbles
                if (w == TAG_WORD) frame_st.count = '0;
                else r.flags[F_UNEXP] = 1'b1;
            end
        endcase

        r.tray      = frame_st.tray;
        r.half      = frame_st.tray_half;
        r.known     = frame_st.tray_seen;
        r.act_count = prior;
        r.phase     = frame_st.phase;
        r.lead      = (r.flags != '0) && !frame_st.reported;
        if (r.flags != '0) frame_st.reported = 1'b1;
        return r;
    endfunction

    // Compare one result field and log the first few mismatches
    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("result %0d: %s expected 0x%0h, got 0x%0h", n_results, name, want, got);
        end
    endfunction

    // Offer one request, hold it until taken, then queue its expected check
    task automatic send_item(input logic [31:0] w, input logic rs, input logic es,
                             input logic typed = 1'b0, input logic [11:0] typed_flags = '0);
        word_check_t want;
        while (src_idle_en && ($urandom_range(99) < IDLE_PCT)) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid        <= 1'b1;
        i_word         <= w;
        i_record_start <= rs;
        i_event_start  <= es;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        want = check_word(w, rs, es);
        if (typed) want.flags = typed_flags;
        flags_seen |= want.flags;
        pending_checks.push_back(want);
        n_words++;
        @(negedge i_clk);
    endtask

    // Drop valid and wait until every queued check has been answered
    task automatic drain_results();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (pending_checks.size() != 0);
    endtask

    // Receiver: random stalls, or one long counted hold-off on request
    initial begin
        i_stall   = 1'b0;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_left != 0) begin
                i_stall   <= 1'b1;
                hold_left = hold_left - 1;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                i_stall   <= 1'b1;
            end else begin
                i_stall <= sink_idle_en && ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    // Result checker: compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            got_res = '{o_error_flags, o_tray_number, o_tray_half, o_tray_known,
                        o_sep_count, o_actual_count, o_expected_phase,
                        o_first_in_record};
            if (pending_checks.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("result %0d: no request outstanding, got flags 0x%03h",
                             n_results, got_res.flags);
            end else begin
                want_res = pending_checks.pop_front();
                check_field("error_flags", 32'(want_res.flags), 32'(got_res.flags));
                check_field("tray_number", 32'(want_res.tray), 32'(got_res.tray));
                check_field("tray_half", 32'(want_res.half), 32'(got_res.half));
                check_field("tray_known", 32'(want_res.known), 32'(got_res.known));
                check_field("sep_count", 32'(want_res.rep_count), 32'(got_res.rep_count));
                check_field("actual_count", 32'(want_res.act_count), 32'(got_res.act_count));
                check_field("expected_phase", 32'(want_res.phase), 32'(got_res.phase));
                check_field("first_in_record", 32'(want_res.lead), 32'(got_res.lead));
            end
            n_results++;
        end
    end

    // Watchdog: end the run when nothing moves for too long
    initial begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < WD_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) quiet = 0;
            else quiet++;
        end
        $display("Timeout: no request moved for %0d cycles", WD_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    // Stimulus
    initial begin
        logic [31:0] rec_words[$];
        logic [31:0] w;
        logic [11:0] phase;
        logic [6:0]  tray;
        logic [9:0]  since;
        logic        corrupt;
        logic        ev;
        logic        lead;
        int unsigned goal;
        int unsigned pick;
        int unsigned idx;
        int unsigned n_data;
        int unsigned n_trays;

        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_word         = '0;
        i_record_start = 1'b0;
        i_event_start  = 1'b0;
        mismatches     = 0;
        n_words        = 0;
        n_results      = 0;
        n_records      = 0;
        flags_seen     = '0;
        src_idle_en    = 1'b1;
        sink_idle_en   = 1'b1;
        hold_req       = 1'b0;
        frame_st.half_parity = 1'b0;
        clear_record();

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table
        for (int k = 0; k < N_DIRECTED; k++)
            send_item(DIRECTED[k].word, DIRECTED[k].rec_start, DIRECTED[k].evt_start,
                      DIRECTED[k].typed, DIRECTED[k].flags);
        drain_results();

        // Back-to-back burst: one framed two-half record, no idling on either side
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        for (int h = 1; h >= 0; h--) begin
            send_item({TOP_GEO, 20'h0, 7'd5, 1'(h)}, h == 1, h == 1);
            send_item({HEADER_BYTE, 12'h0, 12'h5A5}, 1'b0, 1'b0);
            repeat (BURST_DATA) send_item({TOP_DATA_LO, 28'($urandom)}, 1'b0, 1'b0);
            send_item({TOP_SEPARATOR, 10'h0, 10'(BURST_DATA + 1), 8'h0}, 1'b0, 1'b0);
        end
        send_item({TOP_TRIGGER, 28'h0}, 1'b0, 1'b0);
        drain_results();
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;

        // Random part: mostly framed records, some corrupted, plus raw noise
        goal = n_words + RANDOM_ITEMS;
        while (n_words < goal) begin
            if ($urandom_range(99) < 80) begin
                ev      = ($urandom_range(2) == 0);
                corrupt = ($urandom_range(3) == 0);
                phase   = 12'($urandom);
                rec_words.delete();
                if ($urandom_range(3) == 0) rec_words.push_back(TAG_WORD);
                n_trays = $urandom_range(1, 2);
                for (int t = 0; t < n_trays; t++) begin
                    tray = 7'($urandom);
                    // odd half first, so parity ends even before the trigger
                    for (int h = 1; h >= 0; h--) begin
                        rec_words.push_back({TOP_GEO, 20'h0, tray, 1'(h)});
                        if ($urandom_range(3) == 0)
                            rec_words.push_back({TOP_HEADER, 4'($urandom_range(1, 15)),
                                                 12'($urandom), phase});
                        else
                            rec_words.push_back({HEADER_BYTE, 12'($urandom), phase});
                        since  = 10'd1;
                        n_data = $urandom_range(0, 12);
                        for (int d = 0; d < n_data; d++) begin
                            if ($urandom_range(9) == 0)
                                rec_words.push_back({TOP_HEADER, 4'($urandom_range(1, 15)),
                                                     12'($urandom), phase});
                            else
                                rec_words.push_back({($urandom_range(1) == 1) ? TOP_DATA_HI
                                                     : TOP_DATA_LO, 28'($urandom)});
                            since = since + 10'd1;
                        end
                        rec_words.push_back({TOP_SEPARATOR, 10'($urandom), since,
                                             8'($urandom)});
                    end
                end
                rec_words.push_back({TOP_TRIGGER, 28'($urandom)});

                // Send the record, dropping, replacing, flipping or repeating words if corrupt
                lead = 1'b1;
                foreach (rec_words[k]) begin
                    pick = corrupt ? $urandom_range(99) : 100;
                    if (pick >= 4) begin
                        w = rec_words[k];
                        if (pick < 8) begin
                            w = $urandom;
                        end else if (pick < 12) begin
                            idx    = $urandom_range(31);
                            w[idx] = ~w[idx];
                        end
                        send_item(w, lead, lead & ev);
                        lead = 1'b0;
                        if (pick >= 12 && pick < 16) send_item(w, 1'b0, 1'b0);
                    end
                end

                n_records++;
                if (n_records == 6) hold_req = 1'b1;
                if (n_records == 10) drain_results();
            end else begin
                repeat ($urandom_range(1, 5))
                    send_item($urandom, $urandom_range(7) == 0, $urandom_range(15) == 0);
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(negedge i_clk);

        $display("Run covered %0d words: directed table, a back-to-back framed burst",
                 n_words);
        $display("and %0d random records with stalls; error flags raised 0x%03h",
                 n_records, flags_seen);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("%0d field mismatches over %0d results", mismatches, n_results);
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
